@@ rtl/sdgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed depth gated stopwatch package
// Shared widths, reset values, codes and payload types of the stopwatch.
// ----------------------------------------------------------------------------
package sdgs_pkg;

   localparam int WINDOW_MAX     = 16;
   localparam int RING_AW        = $clog2(WINDOW_MAX);
   localparam int FILL_BITS      = $clog2(WINDOW_MAX + 1);
   localparam int DEPTH_BITS     = 13;
   localparam int TIMER_BITS     = 24;
   localparam int SUM_BITS       = 17;
   localparam int SMOOTH_BITS    = 17;
   localparam int FRAC_BITS      = 4;
   localparam int DIVIDEND_BITS  = SUM_BITS + FRAC_BITS;
   localparam int DIV_COUNT_BITS = $clog2(DIVIDEND_BITS + 1);
   localparam int WSIZE_BITS     = 5;
   localparam int PROD_BITS      = DEPTH_BITS + FILL_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;

   localparam logic [WSIZE_BITS-1:0] WINDOW_SIZE_RESET = 5'd10;
   localparam logic [DEPTH_BITS-1:0] START_LOW_RESET   = 13'd5990;
   localparam logic [DEPTH_BITS-1:0] START_HIGH_RESET  = 13'd6000;
   localparam logic [DEPTH_BITS-1:0] STOP_LOW_RESET    = 13'd1000;
   localparam logic [DEPTH_BITS-1:0] STOP_HIGH_RESET   = 13'd1100;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SIZE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_LOW   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_HIGH  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STOP_LOW    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STOP_HIGH   = 3'd4;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   localparam logic [1:0] EVT_NONE  = 2'd0;
   localparam logic [1:0] EVT_START = 2'd1;
   localparam logic [1:0] EVT_STOP  = 2'd2;

   typedef struct packed {
      logic                  action;
      logic [DEPTH_BITS-1:0] depth_mm;
   } req_type;

   typedef struct packed {
      logic [SMOOTH_BITS-1:0] smoothed_depth;
      logic                   timing;
      logic [1:0]             event_res;
      logic [TIMER_BITS-1:0]  elapsed_ms;
   } rsp_type;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [FILL_BITS-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [SMOOTH_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_PUSH,
      ST_START_CHK,
      ST_STOP_CHK,
      ST_WAIT_DIV,
      ST_OUT
   } state_type;

endpackage

@@ rtl/sdgs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sdgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sdgs_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdgs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sdgs_pkg::div_req_type div_req,
   output sdgs_pkg::div_rsp_type div_rsp
);

   import sdgs_pkg::*;

   logic [FILL_BITS-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0]  quo_ff, quo_in;
   logic [FILL_BITS-1:0]      divisor_ff, divisor_in;
   logic [DIV_COUNT_BITS-1:0] count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [FILL_BITS:0]        trial;
   logic [FILL_BITS:0]        diff;
   logic                      fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff       = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = done_ff;
      if (div_req.start) begin
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
         count_in   = DIV_COUNT_BITS'(DIVIDEND_BITS);
         busy_in    = 1'b1;
         done_in    = 1'b0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[FILL_BITS-1:0] : trial[FILL_BITS-1:0];
         quo_in   = {quo_ff[DIVIDEND_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[SMOOTH_BITS-1:0];

endmodule

@@ rtl/smoothed_depth_gated_stopwatch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed depth gated stopwatch
// Moving average of depth samples that starts and stops a millisecond timer.
// ----------------------------------------------------------------------------
// A tick request gives no response. A depth sample is answered after these
// steps: read the oldest ring entry when it has to be dropped, push the new
// sample, test the start window and load the serial divider, then let the
// divider form the average one quotient bit per cycle while the stop window
// is tested as it begins, see it finish and load the output register once
// that register is free. The next request is accepted when the block is back
// in its idle state.
// Samples are held in a 16-entry ring memory and the block works on one
// request at a time; a finished response waits in an output register, and
// ticks are still accepted while it does.
module smoothed_depth_gated_stopwatch (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  sdgs_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output sdgs_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_wr_en,
   input  logic [sdgs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sdgs_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   import sdgs_pkg::*;

   state_type              state_ff, state_in;
   logic [WSIZE_BITS-1:0]  window_size_ff;
   logic [DEPTH_BITS-1:0]  start_low_ff, start_high_ff, stop_low_ff, stop_high_ff;
   logic [RING_AW-1:0]     slot_ff, slot_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                   timing_ff, timing_in;
   logic [TIMER_BITS-1:0]  ticks_ff, ticks_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [1:0]             evt_ff, evt_in;
   logic [TIMER_BITS-1:0]  elapsed_ff, elapsed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [FILL_BITS-1:0]   eff_window;
   logic                   accept;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [RING_AW-1:0]     ram_rd_addr;
   logic [DEPTH_BITS-1:0]  ram_rd_data;
   logic [DEPTH_BITS-1:0]  win_low, win_high;
   logic [PROD_BITS-1:0]   low_prod, high_prod, sum_ext;
   logic                   in_win;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   sdgs_ram #(
      .WIDTH (DEPTH_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (depth_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sdgs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (window_size_ff == '0) begin
         eff_window = FILL_BITS'(1);
      end else if (32'(window_size_ff) > WINDOW_MAX) begin
         eff_window = FILL_BITS'(WINDOW_MAX);
      end else begin
         eff_window = FILL_BITS'(window_size_ff);
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign ram_rd_addr = slot_ff - fill_ff[RING_AW-1:0];

   always_comb begin
      if (state_ff == ST_START_CHK) begin
         win_low  = start_low_ff;
         win_high = start_high_ff;
      end else begin
         win_low  = stop_low_ff;
         win_high = stop_high_ff;
      end
      low_prod  = PROD_BITS'(win_low) * PROD_BITS'(fill_ff);
      high_prod = PROD_BITS'(win_high) * PROD_BITS'(fill_ff);
      sum_ext   = PROD_BITS'(sum_ff);
      in_win    = (sum_ext >= low_prod) && (sum_ext <= high_prod);
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      timing_in    = timing_ff;
      ticks_in     = ticks_ff;
      depth_in     = depth_ff;
      evt_in       = evt_ff;
      elapsed_in   = elapsed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      div_req      = '{start: 1'b0, dividend: {sum_ff, FRAC_BITS'(0)}, divisor: fill_ff};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACTION_TICK) begin
                  if (timing_ff && (ticks_ff != '1)) begin
                     ticks_in = ticks_ff + 1'b1;
                  end
               end else begin
                  depth_in = req_data.depth_mm;
                  evt_in   = EVT_NONE;
                  if ((fill_ff >= eff_window) && (fill_ff != '0)) begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_DROP;
                  end else begin
                     state_in = ST_PUSH;
                  end
               end
            end
         end
         ST_DROP: begin
            sum_in   = sum_ff - SUM_BITS'(ram_rd_data);
            fill_in  = fill_ff - 1'b1;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            ram_wr_en = 1'b1;
            slot_in   = slot_ff + 1'b1;
            fill_in   = fill_ff + 1'b1;
            sum_in    = sum_ff + SUM_BITS'(depth_ff);
            state_in  = ST_START_CHK;
         end
         ST_START_CHK: begin
            div_req.start = 1'b1;
            if (!timing_ff && in_win) begin
               timing_in = 1'b1;
               ticks_in  = '0;
               evt_in    = EVT_START;
            end
            state_in = ST_STOP_CHK;
         end
         ST_STOP_CHK: begin
            elapsed_in = '0;
            if (timing_ff && in_win) begin
               timing_in  = 1'b0;
               evt_in     = EVT_STOP;
               elapsed_in = ticks_ff;
            end
            state_in = ST_WAIT_DIV;
         end
         ST_WAIT_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{smoothed_depth: div_rsp.quotient,
                                timing:         timing_ff,
                                event_res:      evt_ff,
                                elapsed_ms:     elapsed_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         timing_ff    <= 1'b0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         timing_ff    <= timing_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      depth_ff    <= depth_in;
      evt_ff      <= evt_in;
      elapsed_ff  <= elapsed_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         start_low_ff   <= START_LOW_RESET;
         start_high_ff  <= START_HIGH_RESET;
         stop_low_ff    <= STOP_LOW_RESET;
         stop_high_ff   <= STOP_HIGH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[WSIZE_BITS-1:0];
            CSR_START_LOW:   start_low_ff   <= csr_wdata[DEPTH_BITS-1:0];
            CSR_START_HIGH:  start_high_ff  <= csr_wdata[DEPTH_BITS-1:0];
            CSR_STOP_LOW:    stop_low_ff    <= csr_wdata[DEPTH_BITS-1:0];
            CSR_STOP_HIGH:   stop_high_ff   <= csr_wdata[DEPTH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/tb_smoothed_depth_gated_stopwatch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed depth gated stopwatch testbench
// Sends depth and tick requests with random bursts and gaps, stalls the
// response side on a changing pattern and compares every response, field by
// field, with a behavioural copy of the averaging ring and the stopwatch
// kept inside the bench.
// ----------------------------------------------------------------------------
module tb_smoothed_depth_gated_stopwatch;
   import sdgs_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 800;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RANDOM_ITEMS   = 1650;
   localparam int REQ_BITS       = $bits(req_type);
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED = CSR_STOP_HIGH + 1'b1;

   typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic [WSIZE_BITS-1:0] cfg_window     = WINDOW_SIZE_RESET;
   logic [DEPTH_BITS-1:0] cfg_start_low  = START_LOW_RESET;
   logic [DEPTH_BITS-1:0] cfg_start_high = START_HIGH_RESET;
   logic [DEPTH_BITS-1:0] cfg_stop_low   = STOP_LOW_RESET;
   logic [DEPTH_BITS-1:0] cfg_stop_high  = STOP_HIGH_RESET;

   logic [DEPTH_BITS-1:0] ring_copy [WINDOW_MAX];
   logic [RING_AW-1:0]    next_slot         = '0;
   int unsigned           fill_level        = 0;
   int unsigned           depth_sum         = 0;
   bit                    stopwatch_running = 1'b0;
   logic [TIMER_BITS-1:0] ms_count          = '0;

   rsp_type     pending_readings [$];
   int unsigned mismatch_count = 0;
   int unsigned counted_items  = 0;
   int          burst_left     = 0;
   bit          long_hold_req  = 1'b0;

   smoothed_depth_gated_stopwatch dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit mean_between(input logic [DEPTH_BITS-1:0] lo,
                                       input logic [DEPTH_BITS-1:0] hi);
      return depth_sum >= lo * fill_level && depth_sum <= hi * fill_level;
   endfunction

   // Advances the stopwatch copy by one request and queues the reading that a
   // depth sample produces. Returns 0 for a tick while the stopwatch is stopped.
   function automatic bit model_request(input req_type r);
      rsp_type     reading;
      int unsigned span;
      int unsigned oldest;
      if (r.action == ACTION_TICK) begin
         if (!stopwatch_running) return 1'b0;
         if (ms_count != '1) ms_count++;
         return 1'b1;
      end
      span = (cfg_window == 0) ? 1 : (cfg_window > WINDOW_MAX) ? WINDOW_MAX : cfg_window;
      if (fill_level + 1 > span && fill_level > 0) begin
         oldest = (next_slot + WINDOW_MAX - fill_level) % WINDOW_MAX;
         depth_sum -= ring_copy[oldest];
         fill_level--;
      end
      ring_copy[next_slot] = r.depth_mm;
      next_slot++;
      fill_level++;
      depth_sum += r.depth_mm;
      reading.smoothed_depth = SMOOTH_BITS'(depth_sum * 16 / fill_level);
      reading.event_res      = EVT_NONE;
      reading.elapsed_ms     = '0;
      if (!stopwatch_running && mean_between(cfg_start_low, cfg_start_high)) begin
         stopwatch_running = 1'b1;
         ms_count          = '0;
         reading.event_res = EVT_START;
      end
      if (stopwatch_running && mean_between(cfg_stop_low, cfg_stop_high)) begin
         stopwatch_running  = 1'b0;
         reading.event_res  = EVT_STOP;
         reading.elapsed_ms = ms_count;
      end
      reading.timing = stopwatch_running;
      pending_readings.insert(pending_readings.size(), reading);
      return 1'b1;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_WINDOW_SIZE: cfg_window     = data[WSIZE_BITS-1:0];
         CSR_START_LOW:   cfg_start_low  = data[DEPTH_BITS-1:0];
         CSR_START_HIGH:  cfg_start_high = data[DEPTH_BITS-1:0];
         CSR_STOP_LOW:    cfg_stop_low   = data[DEPTH_BITS-1:0];
         CSR_STOP_HIGH:   cfg_stop_high  = data[DEPTH_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [WSIZE_BITS-1:0] ws,
                                 input logic [DEPTH_BITS-1:0] sl,
                                 input logic [DEPTH_BITS-1:0] sh,
                                 input logic [DEPTH_BITS-1:0] tl,
                                 input logic [DEPTH_BITS-1:0] th);
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'($urandom);
      word[WSIZE_BITS-1:0] = ws;
      write_reg(CSR_WINDOW_SIZE, word);
      write_reg(CSR_START_LOW, sl);
      write_reg(CSR_START_HIGH, sh);
      write_reg(CSR_STOP_LOW, tl);
      write_reg(CSR_STOP_HIGH, th);
      write_reg(CSR_FIRST_UNUSED + CSR_INDEX_BITS'($urandom_range(0, 2)),
                CSR_DATA_BITS'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // Valid stays high across a burst and drops only for a gap.
   task automatic send_item(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (model_request(r)) counted_items++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic send_sample(input logic [DEPTH_BITS-1:0] depth);
      req_type r;
      r.action   = ACTION_SAMPLE;
      r.depth_mm = depth;
      send_item(r);
   endtask

   task automatic send_tick();
      req_type r;
      r.action   = ACTION_TICK;
      r.depth_mm = DEPTH_BITS'($urandom);
      send_item(r);
   endtask

   // Mostly a sample between the given depths, now and then an arbitrary request.
   task automatic send_level(input int unsigned lo, input int unsigned hi);
      req_type r;
      if ($urandom_range(0, 11) == 0) begin
         r = REQ_BITS'($urandom);
         send_item(r);
      end else begin
         send_sample(DEPTH_BITS'($urandom_range(lo, hi)));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_window(output logic [DEPTH_BITS-1:0] lo,
                              output logic [DEPTH_BITS-1:0] hi);
      int unsigned centre;
      int unsigned spread;
      case ($urandom_range(0, 9))
         0: begin
            lo = '0;
            hi = DEPTH_MAX;
         end
         1: begin
            lo = DEPTH_BITS'($urandom_range(1, DEPTH_MAX));
            hi = DEPTH_BITS'($urandom_range(0, lo - 1));
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       centre = 0;
               1:       centre = DEPTH_MAX;
               default: centre = $urandom_range(0, DEPTH_MAX);
            endcase
            spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            lo = (centre > spread) ? DEPTH_BITS'(centre - spread) : '0;
            hi = (centre + spread < DEPTH_MAX) ? DEPTH_BITS'(centre + spread) : DEPTH_MAX;
         end
      endcase
   endtask

   // One visit: settle inside the start window, count some ticks, then settle
   // inside the stop window.
   task automatic run_session(input int unsigned span,
                              input logic [DEPTH_BITS-1:0] sl,
                              input logic [DEPTH_BITS-1:0] sh,
                              input logic [DEPTH_BITS-1:0] tl,
                              input logic [DEPTH_BITS-1:0] th);
      repeat (span + $urandom_range(0, 2)) send_level(sl, sh);
      repeat ($urandom_range(0, 30)) send_tick();
      repeat (span + $urandom_range(0, 2)) send_level(tl, th);
   endtask

   task automatic test_reset_defaults();
      send_sample(13'd5995);
      send_tick();
      send_tick();
      send_sample(DEPTH_MAX);
      wait_idle();
   endtask

   task automatic test_start_stop();
      write_settings(5'd1, DEPTH_MAX, DEPTH_MAX, 13'd0, 13'd0);
      send_sample(13'd0);
      send_tick();
      send_sample(DEPTH_MAX);
      send_tick();
      send_tick();
      send_tick();
      send_sample(DEPTH_MAX);
      send_sample(13'd0);
      wait_idle();
   endtask

   task automatic test_same_sample_start_stop();
      write_settings(5'd0, 13'd100, 13'd200, 13'd150, 13'd300);
      send_sample(13'd160);
      send_tick();
      send_sample(13'd120);
      send_tick();
      send_sample(13'd250);
      wait_idle();
   endtask

   task automatic test_inverted_window();
      write_settings(5'd31, 13'd500, 13'd400, 13'd0, DEPTH_MAX);
      send_sample(13'd450);
      send_sample(DEPTH_MAX);
      send_sample(13'd0);
      wait_idle();
      write_settings(5'd2, 13'd0, DEPTH_MAX, 13'd500, 13'd400);
      send_sample(13'd450);
      send_tick();
      send_sample(13'd7);
      wait_idle();
   endtask

   task automatic test_random_sessions(input int unsigned target);
      int unsigned           phase;
      int unsigned           span;
      int unsigned           phase_end;
      logic [WSIZE_BITS-1:0] ws;
      logic [DEPTH_BITS-1:0] sl, sh, tl, th;
      phase = 0;
      while (counted_items < target) begin
         case (phase % 6)
            0:       ws = 5'd1;
            1:       ws = WSIZE_BITS'(WINDOW_MAX);
            2:       ws = 5'd0;
            3:       ws = WSIZE_BITS'($urandom_range(WINDOW_MAX + 1, 31));
            default: ws = WSIZE_BITS'($urandom_range(2, WINDOW_MAX - 1));
         endcase
         pick_window(sl, sh);
         pick_window(tl, th);
         wait_idle();
         write_settings(ws, sl, sh, tl, th);
         span = (ws == 0) ? 1 : (ws > WINDOW_MAX) ? WINDOW_MAX : ws;
         phase_end = counted_items + 110;
         while (counted_items < phase_end) run_session(span, sl, sh, tl, th);
         phase++;
      end
      wait_idle();
   endtask

   task automatic test_output_stall();
      long_hold_req = 1'b1;
      burst_left    = 80;
      repeat (40) send_level(0, DEPTH_MAX);
      wait_idle();
   endtask

   initial begin
      int unsigned hold_count;
      int unsigned mode_left;
      int unsigned beat;
      rx_mode_type mode;
      hold_count = 0;
      mode_left  = 0;
      beat       = 0;
      mode       = RX_FREE;
      forever begin
         @(posedge clock);
         beat++;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_count    = LONG_HOLD;
            rsp_ready    <= 1'b0;
         end else if (hold_count > 0) begin
            hold_count--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               RX_FREE:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= (beat % 3 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected response: smoothed_depth %0d event_res %0d",
                   rsp_data.smoothed_depth, rsp_data.event_res);
            mismatch_count++;
         end else begin
            want = pending_readings[0];
            pending_readings.delete(0);
            if (rsp_data.smoothed_depth !== want.smoothed_depth) begin
               $error("smoothed_depth: expected %0d, got %0d",
                      want.smoothed_depth, rsp_data.smoothed_depth);
               mismatch_count++;
            end
            if (rsp_data.timing !== want.timing) begin
               $error("timing: expected %0d, got %0d", want.timing, rsp_data.timing);
               mismatch_count++;
            end
            if (rsp_data.event_res !== want.event_res) begin
               $error("event_res: expected %0d, got %0d",
                      want.event_res, rsp_data.event_res);
               mismatch_count++;
            end
            if (rsp_data.elapsed_ms !== want.elapsed_ms) begin
               $error("elapsed_ms: expected %0d, got %0d",
                      want.elapsed_ms, rsp_data.elapsed_ms);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_start_stop();
      test_same_sample_start_stop();
      test_inverted_window();
      test_random_sessions(RANDOM_ITEMS / 2);
      test_output_stall();
      test_random_sessions(RANDOM_ITEMS);
      wait_idle();
      if (mismatch_count == 0 && pending_readings.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ smoothed_depth_gated_stopwatch.f @@
rtl/sdgs_pkg.sv
rtl/sdgs_ram.sv
rtl/sdgs_divider.sv
rtl/smoothed_depth_gated_stopwatch.sv
tb/tb_smoothed_depth_gated_stopwatch.sv
